[sv/lisfw_pkg.sv]
`default_nettype none

package lisfw_pkg;

    // Default widths of a sequence element and of a run length
    localparam int LISFW_VALUE_BITS = 10;
    localparam int LISFW_LEN_BITS   = 16;

endpackage

`default_nettype wire

[sv/lis_length_fenwick_max.sv]
`default_nettype none

// Longest strictly increasing subsequence over a stream of unsigned values.
// Slave stream: s_axis_tdata carries one element, s_axis_tlast marks the
// final element of a sequence. Master stream: m_axis_tdata carries the run
// length ending at that element and the best length so far; m_axis_tlast
// repeats the input's last flag. One result per element.
// Each element walks a Fenwick tree of prefix maxima held in one memory
// with a write port and a registered read port: a downward walk reads the
// entries below the value and takes their maximum, then an upward walk
// reads each covering entry and writes the new run length where it is
// larger. Lengths saturate at 2^LEN_BITS-1.
// After reset, and after each element marked last once its result has been
// handed to the output register, the whole tree is swept to zero with
// s_axis_tready low.
// The result sits in an output register; when the receiver stalls, the next
// element's walk still runs and then waits for the register to drain.
module lis_length_fenwick_max
    import lisfw_pkg::*;
#(
    parameter int VALUE_BITS = LISFW_VALUE_BITS,
    parameter int LEN_BITS   = LISFW_LEN_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // value
    input  wire logic [((VALUE_BITS + 7) / 8)*8-1:0]  s_axis_tdata,
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // ending_length, best_length
    output logic      [((2*LEN_BITS + 7) / 8)*8-1:0]  m_axis_tdata,
    output logic                                      m_axis_tlast
);

    localparam int OUT_W = ((2*LEN_BITS + 7) / 8) * 8;

    logic                  w_res_valid;
    logic                  w_out_free;
    logic [LEN_BITS-1:0]   w_res_ending;
    logic [LEN_BITS-1:0]   w_res_best;
    logic                  w_res_last;
    logic                  w_wr_en;
    logic [VALUE_BITS-1:0] w_wr_addr;
    logic [LEN_BITS-1:0]   w_wr_data;
    logic                  w_rd_en;
    logic [VALUE_BITS-1:0] w_rd_addr;
    logic [LEN_BITS-1:0]   w_rd_data;

    logic                  r_out_vld;
    logic [LEN_BITS-1:0]   r_out_ending;
    logic [LEN_BITS-1:0]   r_out_best;
    logic                  r_out_last;

    lisfw_seq #(
        .VALUE_BITS (VALUE_BITS),
        .LEN_BITS   (LEN_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_value       (s_axis_tdata[VALUE_BITS-1:0]),
        .i_last        (s_axis_tlast),
        .o_res_valid   (w_res_valid),
        .i_out_free    (w_out_free),
        .o_res_ending  (w_res_ending),
        .o_res_best    (w_res_best),
        .o_res_last    (w_res_last),
        .o_mem_wr_en   (w_wr_en),
        .o_mem_wr_addr (w_wr_addr),
        .o_mem_wr_data (w_wr_data),
        .o_mem_rd_en   (w_rd_en),
        .o_mem_rd_addr (w_rd_addr),
        .i_mem_rd_data (w_rd_data)
    );

    lisfw_tree_mem #(
        .VALUE_BITS (VALUE_BITS),
        .LEN_BITS   (LEN_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register is free when empty or drained this cycle
    assign w_out_free = !r_out_vld || m_axis_tready;

    // Load a finished result, hold it while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_res_valid;
        end
        if (w_out_free && w_res_valid) begin
            r_out_ending <= w_res_ending;
            r_out_best   <= w_res_best;
            r_out_last   <= w_res_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_out_best, r_out_ending});
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[sv/lisfw_tree_mem.sv]
`default_nettype none

module lisfw_tree_mem
    import lisfw_pkg::*;
#(
    parameter int VALUE_BITS = LISFW_VALUE_BITS,
    parameter int LEN_BITS   = LISFW_LEN_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [VALUE_BITS-1:0] i_wr_addr,
    input  wire logic [LEN_BITS-1:0]   i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [VALUE_BITS-1:0] i_rd_addr,
    output logic      [LEN_BITS-1:0]   o_rd_data
);

    localparam int DEPTH = 1 << VALUE_BITS;

    // Fenwick tree entries, position p held at address p-1
    logic [LEN_BITS-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/lisfw_seq.sv]
`default_nettype none

module lisfw_seq
    import lisfw_pkg::*;
#(
    parameter int VALUE_BITS = LISFW_VALUE_BITS,
    parameter int LEN_BITS   = LISFW_LEN_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_last,
    // result towards the output register
    output logic                       o_res_valid,
    input  wire logic                  i_out_free,
    output logic      [LEN_BITS-1:0]   o_res_ending,
    output logic      [LEN_BITS-1:0]   o_res_best,
    output logic                       o_res_last,
    // tree memory
    output logic                       o_mem_wr_en,
    output logic      [VALUE_BITS-1:0] o_mem_wr_addr,
    output logic      [LEN_BITS-1:0]   o_mem_wr_data,
    output logic                       o_mem_rd_en,
    output logic      [VALUE_BITS-1:0] o_mem_rd_addr,
    input  wire logic [LEN_BITS-1:0]   i_mem_rd_data
);

    // Position register covers 0 .. 2*DOMAIN during the upward walk
    localparam int PW = VALUE_BITS + 2;
    localparam logic [PW-1:0] DOMAIN = PW'(1) << VALUE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_UPDATE,
        ST_DONE
    } t_state;

    t_state                r_state,    n_state;
    logic [PW-1:0]         r_pos,      n_pos;
    logic [LEN_BITS-1:0]   r_max,      n_max;
    logic [LEN_BITS-1:0]   r_len,      n_len;
    logic [LEN_BITS-1:0]   r_best,     n_best;
    logic [VALUE_BITS-1:0] r_val,      n_val;
    logic                  r_last,     n_last;
    logic                  r_rd_vld,   n_rd_vld;
    logic [VALUE_BITS-1:0] r_rd_addr,  n_rd_addr;
    logic [VALUE_BITS-1:0] r_clr_addr, n_clr_addr;

    logic [PW-1:0]         w_pos_m1;
    logic [PW-1:0]         w_lowbit;

    assign w_pos_m1 = r_pos - PW'(1);
    assign w_lowbit = r_pos & (~r_pos + PW'(1));

    assign o_mem_rd_addr = w_pos_m1[VALUE_BITS-1:0];
    assign o_res_ending  = r_len;
    assign o_res_best    = r_best;
    assign o_res_last    = r_last;

    // Sequencer: downward max walk, then upward raise walk
    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_max         = r_max;
        n_len         = r_len;
        n_best        = r_best;
        n_val         = r_val;
        n_last        = r_last;
        n_rd_vld      = 1'b0;
        n_rd_addr     = r_rd_addr;
        n_clr_addr    = r_clr_addr;
        o_in_ready    = 1'b0;
        o_res_valid   = 1'b0;
        o_mem_rd_en   = 1'b0;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_rd_addr;
        o_mem_wr_data = r_len;
        case (r_state)
            ST_CLEAR: begin
                // sweep zeros through the whole tree
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_clr_addr;
                o_mem_wr_data = '0;
                n_clr_addr    = r_clr_addr + VALUE_BITS'(1);
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_val   = i_value;
                    n_last  = i_last;
                    n_pos   = PW'(i_value);
                    n_max   = '0;
                    n_state = ST_QUERY;
                end
            end
            ST_QUERY: begin
                // fold in the entry read last cycle
                if (r_rd_vld && (i_mem_rd_data > r_max)) begin
                    n_max = i_mem_rd_data;
                end
                if (r_pos != '0) begin
                    o_mem_rd_en = 1'b1;
                    n_rd_vld    = 1'b1;
                    n_pos       = r_pos & w_pos_m1;
                end else if (!r_rd_vld) begin
                    // saturating increment of the prefix maximum
                    n_len   = (&r_max) ? r_max : r_max + LEN_BITS'(1);
                    n_pos   = PW'(r_val) + PW'(1);
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // raise the entry read last cycle if it is below the new length
                if (r_rd_vld && (i_mem_rd_data < r_len)) begin
                    o_mem_wr_en = 1'b1;
                end
                if (r_pos <= DOMAIN) begin
                    o_mem_rd_en = 1'b1;
                    n_rd_vld    = 1'b1;
                    n_rd_addr   = w_pos_m1[VALUE_BITS-1:0];
                    n_pos       = r_pos + w_lowbit;
                end else if (!r_rd_vld) begin
                    if (r_len > r_best) begin
                        n_best = r_len;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_out_free) begin
                    if (r_last) begin
                        n_best     = '0;
                        n_clr_addr = '0;
                        n_state    = ST_CLEAR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_best     <= '0;
            r_rd_vld   <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_best     <= n_best;
            r_rd_vld   <= n_rd_vld;
            r_clr_addr <= n_clr_addr;
        end
        r_pos     <= n_pos;
        r_max     <= n_max;
        r_len     <= n_len;
        r_val     <= n_val;
        r_last    <= n_last;
        r_rd_addr <= n_rd_addr;
    end

endmodule

`default_nettype wire
